### rtl/sssc_pkg.sv
// ----------------------------------------------------------------------------
// sssc_pkg
// Shared types, constants and the character decoder of the scrolling
// seven-segment scanner.
// ----------------------------------------------------------------------------
package sssc_pkg;

    localparam int DIGIT_COUNT   = 4;
    localparam int DIGIT_W       = 2;
    localparam int POS_W         = 6;
    localparam int CHAR_W        = 8;
    localparam int SEG_W         = 7;
    localparam int INDEX_W       = 6;
    localparam int PERIOD_W      = 16;
    localparam int LENGTH_W      = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int VISIBLE_CHARS = 4;

    localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RESET = 16'd400;
    localparam logic [LENGTH_W-1:0] TEXT_LENGTH_RESET   = 7'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH   = 2'd1;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [DIGIT_W-1:0] digit;
    } t_scan;

    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        logic [SEG_W-1:0]  seg;
        c = code;
        if (code >= 8'h61 && code <= 8'h7a) begin
            c = code - 8'h20;
        end
        case (c)
            8'h41:   seg = 7'h77; // A
            8'h43:   seg = 7'h39; // C
            8'h45:   seg = 7'h79; // E
            8'h46:   seg = 7'h71; // F
            8'h48:   seg = 7'h76; // H
            8'h49:   seg = 7'h06; // I
            8'h4c:   seg = 7'h38; // L
            8'h4f:   seg = 7'h3f; // O
            8'h50:   seg = 7'h73; // P
            8'h53:   seg = 7'h6d; // S
            8'h55:   seg = 7'h3e; // U
            8'h59:   seg = 7'h6e; // Y
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

### rtl/sssc_if.sv
// ----------------------------------------------------------------------------
// sssc_if
// Valid/ready channels of the scrolling seven-segment scanner: input items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface sssc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [sssc_pkg::INDEX_W-1:0] char_index;
    logic [sssc_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output opcode, output char_index, output char_code,
                    input ready);
    modport sink   (input valid, input opcode, input char_index, input char_code,
                    output ready);
endinterface

interface sssc_out_if;
    logic                           valid;
    logic                           ready;
    logic [sssc_pkg::SEG_W-1:0]     segments;
    logic [sssc_pkg::DIGIT_COUNT-1:0] digit_select_n;
    logic [sssc_pkg::DIGIT_W-1:0]   digit_index;

    modport source (output valid, output segments, output digit_select_n,
                    output digit_index, input ready);
    modport sink   (input valid, input segments, input digit_select_n,
                    input digit_index, output ready);
endinterface

interface sssc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sssc_pkg::CFG_IDX_W-1:0]  index;
    logic [sssc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/scrolling_seven_segment_scanner_top.sv
// ----------------------------------------------------------------------------
// scrolling_seven_segment_scanner_top
// Four-digit multiplexed seven-segment scanner that scrolls a stored text.
// ----------------------------------------------------------------------------
// result path: a tick item's text buffer entry is read at the accepting edge,
// then the character is decoded into the result register
// throughput: one item per cycle, loads and ticks alike, while the output is not stalled
// reset: synchronous, active low; the text buffer reads as blank through
// per-entry valid bits cleared at once, no clearing pass
// ----------------------------------------------------------------------------
module scrolling_seven_segment_scanner_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sssc_in_if.sink     i_in,
    sssc_out_if.source  o_out,
    sssc_cfg_if.sink    i_cfg
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int WW      = 9;
    localparam int NSUB    = (sssc_pkg::VISIBLE_CHARS + 63) / BUFFER_DEPTH + 1;

    function automatic logic [AW-1:0] wrap_addr(input logic [WW-1:0] v);
        logic [WW-1:0] r;
        r = v;
        for (int k = 0; k < NSUB; k++) begin
            if (r >= WW'(BUFFER_DEPTH)) begin
                r = r - WW'(BUFFER_DEPTH);
            end
        end
        return r[AW-1:0];
    endfunction

    sssc_pkg::t_scan scan;

    logic                          take;
    logic                          in_acc;
    logic                          load_acc;
    logic                          tick_acc;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic [sssc_pkg::CHAR_W-1:0]   rdata;
    logic [sssc_pkg::CHAR_W-1:0]   char_q;

    logic [BUFFER_DEPTH-1:0]       r_entry_vld;
    logic                          r_s1_vld;
    logic                          r_s1_entry;
    logic [sssc_pkg::DIGIT_W-1:0]  r_s1_digit;

    assign i_in.ready = !r_s1_vld || take;
    assign in_acc     = i_in.valid && i_in.ready;
    assign load_acc   = in_acc && (i_in.opcode == sssc_pkg::OP_LOAD);
    assign tick_acc   = in_acc && (i_in.opcode == sssc_pkg::OP_TICK);

    assign waddr = wrap_addr(WW'(i_in.char_index));
    assign raddr = wrap_addr(WW'(scan.pos) + WW'(scan.digit));

    sssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_acc),
        .i_cfg   (i_cfg),
        .o_scan  (scan)
    );

    sssc_ram #(
        .WIDTH (sssc_pkg::CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_text (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (waddr),
        .i_wdata (i_in.char_code),
        .i_re    (tick_acc),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_s1_vld    <= 1'b0;
        end else begin
            if (load_acc) begin
                r_entry_vld[waddr] <= 1'b1;
            end
            if (tick_acc) begin
                r_s1_vld <= 1'b1;
            end else if (take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_entry <= r_entry_vld[raddr];
            r_s1_digit <= scan.digit;
        end
    end

    // entries never loaded read as blank
    assign char_q = r_s1_entry ? rdata : '0;

    sssc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_char  (char_q),
        .i_digit (r_s1_digit),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

### rtl/sssc_ram.sv
// ----------------------------------------------------------------------------
// sssc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sssc_ctrl.sv
// ----------------------------------------------------------------------------
// sssc_ctrl
// Configuration registers, scan digit counter, scroll tick counter and
// scroll position.
// ----------------------------------------------------------------------------
module sssc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    sssc_cfg_if.sink          i_cfg,
    output sssc_pkg::t_scan   o_scan
);

    logic [sssc_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [sssc_pkg::LENGTH_W-1:0] r_length, n_length;
    logic [sssc_pkg::PERIOD_W-1:0] r_count,  n_count;
    logic [sssc_pkg::POS_W-1:0]    r_pos,    n_pos;
    logic [sssc_pkg::DIGIT_W-1:0]  r_digit,  n_digit;

    logic [sssc_pkg::PERIOD_W-1:0] inc_count;
    logic [sssc_pkg::POS_W-1:0]    step_pos;
    logic [sssc_pkg::POS_W+1:0]    pos_end;

    assign i_cfg.ready = 1'b1;

    // register writes
    always_comb begin
        n_period = r_period;
        n_length = r_length;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sssc_pkg::CFG_SCROLL_PERIOD: n_period = i_cfg.data;
                sssc_pkg::CFG_TEXT_LENGTH:   n_length = i_cfg.data[sssc_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // scan and scroll
    always_comb begin
        inc_count = r_count + 1'b1;
        step_pos  = r_pos;
        n_count   = r_count;
        n_pos     = r_pos;
        n_digit   = r_digit;
        if (inc_count == r_period) begin
            step_pos = r_pos + 1'b1;
        end
        pos_end = {2'b00, step_pos} + (sssc_pkg::POS_W+2)'(sssc_pkg::VISIBLE_CHARS);
        if (i_tick) begin
            n_digit = r_digit + 1'b1;
            n_count = (inc_count == r_period) ? '0 : inc_count;
            n_pos   = (pos_end >= {1'b0, r_length}) ? '0 : step_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sssc_pkg::SCROLL_PERIOD_RESET;
            r_length <= sssc_pkg::TEXT_LENGTH_RESET;
            r_count  <= '0;
            r_pos    <= '0;
            r_digit  <= '0;
        end else begin
            r_period <= n_period;
            r_length <= n_length;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_digit  <= n_digit;
        end
    end

    assign o_scan.pos   = r_pos;
    assign o_scan.digit = r_digit;

endmodule

### rtl/sssc_out.sv
// ----------------------------------------------------------------------------
// sssc_out
// Character decode and result register with digit select generation.
// ----------------------------------------------------------------------------
module sssc_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [sssc_pkg::CHAR_W-1:0]   i_char,
    input  logic [sssc_pkg::DIGIT_W-1:0]  i_digit,
    output logic                          o_take,
    sssc_out_if.source                    o_out
);

    logic                              r_valid;
    logic [sssc_pkg::SEG_W-1:0]        r_segments;
    logic [sssc_pkg::DIGIT_COUNT-1:0]  r_select_n;
    logic [sssc_pkg::DIGIT_W-1:0]      r_digit;

    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_segments <= sssc_pkg::glyph_of(i_char);
            r_select_n <= ~(sssc_pkg::DIGIT_COUNT'(1) << i_digit);
            r_digit    <= i_digit;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.segments       = r_segments;
    assign o_out.digit_select_n = r_select_n;
    assign o_out.digit_index    = r_digit;

endmodule
